>>> design/cqmq_pkg.sv
`timescale 1ns / 1ps

package cqmq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 5;
  localparam int KEY_W  = 16;
  localparam int DUR_W  = 16;
  localparam int OP_W   = 2;
  localparam int STS_W  = 2;
  localparam int IN_W   = KEY_W + DUR_W;
  localparam int OUT_RAW_W = KEY_W + DUR_W + CNT_W;
  localparam int OUT_W  = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_in;     // latch request fields
    logic    cfg_write;   // new capacity, queue emptied
    logic    set_status;  // status <- sts, result fields cleared
    status_e sts;
    logic    enq_commit;  // write at tail, bump tail and count
    logic    rd_head;     // read head slot, arm scan
    logic    deq_commit;  // take read data, bump head, drop count
    logic    scan_step;   // fold one entry into the running max
    logic    load_out;    // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic scan_last;
    logic out_free;
  } stat_t;

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (int'(c) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] n;
    n = (CNT_W + 1)'(idx) + (CNT_W + 1)'(1);
    return (n >= (CNT_W + 1)'(cap)) ? '0 : IDX_W'(n);
  endfunction

endpackage

>>> design/cqmq_ctrl.sv
`timescale 1ns / 1ps

module cqmq_ctrl import cqmq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DEQ  = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sts = STS_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.cfg_write = cfg_valid_i;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_ENQ: begin
            cmd_o.set_status = 1'b1;
            if (stat_i.full) begin
              cmd_o.sts = STS_FULL;
            end else begin
              cmd_o.enq_commit = 1'b1;
            end
            state_d = S_DONE;
          end
          OP_DEQ, OP_QUERY: begin
            cmd_o.set_status = 1'b1;
            if (stat_i.empty) begin
              cmd_o.sts = STS_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d = (stat_i.op == OP_DEQ) ? S_DEQ : S_SCAN;
            end
          end
          default: begin
            cmd_o.set_status = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_DEQ: begin
        cmd_o.deq_commit = 1'b1;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/cqmq_dp.sv
`timescale 1ns / 1ps

module cqmq_dp import cqmq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic [OP_W-1:0]  in_op_i,
  input  logic [KEY_W-1:0] in_id_i,
  input  logic [DUR_W-1:0] in_dur_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [STS_W-1:0] out_status_o,
  output logic [KEY_W-1:0] out_id_o,
  output logic [DUR_W-1:0] out_dur_o,
  output logic [CNT_W-1:0] out_held_o
);

  logic [KEY_W+DUR_W-1:0] mem [DEPTH];
  logic [KEY_W+DUR_W-1:0] rd_q;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;

  logic [CFG_W-1:0] cap_q;
  logic [CNT_W-1:0] cap;
  logic [IDX_W-1:0] head_q, tail_q, scan_q;
  logic [CNT_W-1:0] count_q, left_q;
  logic             found_q, out_valid_q;
  op_e              op_q;
  logic [KEY_W-1:0] id_q, rid_q, oid_q;
  logic [DUR_W-1:0] dur_q, rdur_q, odur_q;
  status_e          sts_q, osts_q;
  logic [CNT_W-1:0] oheld_q;
  logic [KEY_W-1:0] rd_id;
  logic [DUR_W-1:0] rd_dur;

  assign cap    = eff_cap(cap_q);
  assign rd_id  = rd_q[KEY_W-1:0];
  assign rd_dur = rd_q[KEY_W+DUR_W-1:KEY_W];

  // head read on arm; during the scan, prefetch the next slot unless last
  assign rd_en   = cmd_i.rd_head || (cmd_i.scan_step && (left_q != CNT_W'(1)));
  assign rd_addr = cmd_i.rd_head ? head_q : scan_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_commit) begin
      mem[tail_q] <= {dur_q, id_q};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q >= cap);
  assign stat_o.scan_last = (left_q == CNT_W'(1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CFG_W'(16);
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      left_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_write) begin
        cap_q   <= cfg_data_i;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
      end
      if (cmd_i.enq_commit) begin
        tail_q  <= advance(tail_q, cap);
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.rd_head) begin
        scan_q  <= advance(head_q, cap);
        left_q  <= count_q;
        found_q <= 1'b0;
      end
      if (cmd_i.deq_commit) begin
        head_q  <= advance(head_q, cap);
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.scan_step) begin
        found_q <= 1'b1;
        left_q  <= left_q - CNT_W'(1);
        if (rd_en) begin
          scan_q <= advance(scan_q, cap);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_e'(in_op_i);
      id_q  <= in_id_i;
      dur_q <= in_dur_i;
    end
    if (cmd_i.set_status) begin
      sts_q  <= cmd_i.sts;
      rid_q  <= '0;
      rdur_q <= '0;
    end
    if (cmd_i.deq_commit) begin
      rid_q  <= rd_id;
      rdur_q <= rd_dur;
    end
    // strict greater keeps the oldest on ties
    if (cmd_i.scan_step && (!found_q || (rd_dur > rdur_q))) begin
      rid_q  <= rd_id;
      rdur_q <= rd_dur;
    end
    if (cmd_i.load_out) begin
      osts_q  <= sts_q;
      oid_q   <= rid_q;
      odur_q  <= rdur_q;
      oheld_q <= count_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = osts_q;
  assign out_id_o     = oid_q;
  assign out_dur_o    = odur_q;
  assign out_held_o   = oheld_q;

endmodule

>>> design/circular_queue_with_max_query.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tuser: op; tdata: entry_id, entry_duration
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tuser: status; tdata: id, duration, held
// cfg       in   cfg_valid_i/cfg_ready_o         cfg_data_i: capacity_in_use
//
// Steps: enqueue, no-op and empty/full requests go from execute to the result register;
//   dequeue adds a read step, a max query one scan step per held entry (one slot per cycle
//   through the single read port of the entry store); then the controller returns to idle.
// One request in flight; a result can wait on m_axis while the next request is accepted.
// Reset: async active low; queue empty, capacity 16. Entry store is not cleared.
// A stalled m_axis holds the result; a finished request then waits in its last step.

module circular_queue_with_max_query import cqmq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // [15:0] entry_id, [31:16] entry_duration
  input  logic [OP_W-1:0]  s_axis_tuser_i,   // [1:0] op
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // [15:0] result_id, [31:16] result_duration,
                                             // [36:32] entries_held, rest zero
  output logic [STS_W-1:0] m_axis_tuser_o,   // [1:0] status
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  logic [KEY_W-1:0] res_id;
  logic [DUR_W-1:0] res_dur;
  logic [CNT_W-1:0] res_held;

  // sequencing: accept, execute, read/scan, deliver
  cqmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // pointers, count, entry store, running max and output register
  cqmq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_op_i      (s_axis_tuser_i),
    .in_id_i      (s_axis_tdata_i[KEY_W-1:0]),
    .in_dur_i     (s_axis_tdata_i[KEY_W+DUR_W-1:KEY_W]),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_id_o     (res_id),
    .out_dur_o    (res_dur),
    .out_held_o   (res_held)
  );

  assign m_axis_tdata_o = OUT_W'({res_held, res_dur, res_id});

endmodule

>>> design/cqmq_checker.sv
`timescale 1ns / 1ps

module cqmq_checker import cqmq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic [STS_W-1:0] m_axis_tuser_o
);

  logic [CNT_W-1:0] held;
  logic [KEY_W+DUR_W-1:0] res;
  assign held = m_axis_tdata_o[KEY_W+DUR_W+CNT_W-1:KEY_W+DUR_W];
  assign res  = m_axis_tdata_o[KEY_W+DUR_W-1:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while one is in flight");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> int'(held) <= DEPTH)
    else $error("entries_held beyond depth");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STS_EMPTY) |-> (res == '0) && (held == '0))
    else $error("empty result carries data or count");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STS_FULL) |-> (res == '0) && (held != '0))
    else $error("full result carries data or zero count");

endmodule

bind circular_queue_with_max_query cqmq_checker u_cqmq_checker (.*);
